[design/trkodo_pkg.sv]
// trkodo_pkg: shared types, fixed-point constants and the arctangent table
// for the tracking wheel odometry block; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package trkodo_pkg;

	localparam int CW  = 40;  // cordic datapath width
	localparam int MW  = 34;  // multiplier operand width
	localparam int PW  = 2 * MW;
	localparam int AW  = 80;  // accumulator width
	localparam int FW  = 45;  // chord factor width
	localparam int DVW = 64;  // divider dividend width
	localparam int DSW = 34;  // divider divisor width
	localparam int TW  = 48;  // rounded partial sum width

	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic [17:0] PI_Q16   = 18'd205887;
	localparam logic [30:0] PI_Q29   = 31'd1686629713;

	localparam logic signed [AW-1:0] SAT_POS = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SAT_NEG = -AW'(64'sd2147483648);

	localparam logic CMD_UPDATE   = 1'b0;
	localparam logic CMD_SET_POSE = 1'b1;

	localparam logic [2:0] REG_WHEEL_DIAMETER  = 3'd0;
	localparam logic [2:0] REG_SIDEWAYS_OFFSET = 3'd1;
	localparam logic [2:0] REG_FORWARD_OFFSET  = 3'd2;
	localparam logic [2:0] REG_START_X         = 3'd3;
	localparam logic [2:0] REG_START_Y         = 3'd4;
	localparam logic [2:0] REG_START_HEADING   = 3'd5;

	typedef struct packed {
		logic issue;
		logic clear;  // start a new sum
		logic hi;     // weight product by 2^32
	} mac_ctl_t;

	// arctangent of 2^-i in 2^32 units per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// round half up at a fixed binary point
	function automatic logic signed [AW-1:0] rnd_shift(input logic signed [AW-1:0] v,
			input int n);
		logic signed [AW-1:0] h;
		h = AW'(1) <<< (n - 1);
		return (v + h) >>> n;
	endfunction

endpackage

`default_nettype wire

[design/trkodo_mac.sv]
// trkodo_mac: shared signed multiply-accumulate unit, product registered
// before the accumulator; depends on trkodo_pkg
`timescale 1ns / 1ps
`default_nettype none

module trkodo_mac (
	input  wire                               clk,
	input  wire                               arst_n,
	input  trkodo_pkg::mac_ctl_t              ctl,
	input  wire logic signed [trkodo_pkg::MW-1:0] a,
	input  wire logic signed [trkodo_pkg::MW-1:0] b,
	output logic                              busy,
	output logic signed [trkodo_pkg::AW-1:0]  acc
);

	logic                             v_s1, clr_s1, hi_s1;
	logic signed [trkodo_pkg::PW-1:0] prod_s1;
	logic signed [trkodo_pkg::AW-1:0] acc_q;
	logic signed [trkodo_pkg::AW-1:0] ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		clr_s1  <= ctl.clear;
		hi_s1   <= ctl.hi;
		prod_s1 <= a * b;
		if (v_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + (hi_s1 ? (ext <<< 32) : ext);
		end
	end

	assign ext  = trkodo_pkg::AW'(prod_s1);
	assign busy = v_s1;
	assign acc  = acc_q;

endmodule

`default_nettype wire

[design/trkodo_cordic.sv]
// trkodo_cordic: iterative rotation-mode cordic, one micro-rotation a cycle;
// depends on trkodo_pkg for the arctangent table
`timescale 1ns / 1ps
`default_nettype none

module trkodo_cordic #(
	parameter int STEPS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire logic signed [trkodo_pkg::CW-1:0] x0,
	input  wire logic signed [trkodo_pkg::CW-1:0] y0,
	input  wire logic signed [trkodo_pkg::CW-1:0] z0,
	output logic                                  done,
	output logic signed [trkodo_pkg::CW-1:0]      x,
	output logic signed [trkodo_pkg::CW-1:0]      y
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                             run_q, done_q;
	logic [IW-1:0]                    cnt_q;
	logic signed [trkodo_pkg::CW-1:0] x_q, y_q, z_q;
	logic signed [trkodo_pkg::CW-1:0] dx, dy, at;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = trkodo_pkg::CW'(trkodo_pkg::atan_turn(5'(cnt_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IW'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (run_q) begin
			if (!z_q[trkodo_pkg::CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;

endmodule

`default_nettype wire

[design/trkodo_div.sv]
// trkodo_div: restoring unsigned divider, one quotient bit a cycle;
// depends on trkodo_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module trkodo_div (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [trkodo_pkg::DVW-1:0]       dividend,
	input  wire [trkodo_pkg::DSW-1:0]       divisor,
	output logic                            done,
	output logic [trkodo_pkg::FW-1:0]       quot
);

	localparam int CNW = $clog2(trkodo_pkg::DVW);

	logic                         run_q, done_q;
	logic [CNW-1:0]               cnt_q;
	logic [trkodo_pkg::DSW-1:0]   rem_q, dsr_q;
	logic [trkodo_pkg::DVW-1:0]   quo_q;
	logic [trkodo_pkg::DSW:0]     trial, diff;
	logic                         fits;

	assign trial = {rem_q, quo_q[trkodo_pkg::DVW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(trkodo_pkg::DVW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[trkodo_pkg::DSW-1:0] : trial[trkodo_pkg::DSW-1:0];
			quo_q <= {quo_q[trkodo_pkg::DVW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q[trkodo_pkg::FW-1:0];

endmodule

`default_nettype wire

[design/tracking_wheel_odometry.sv]
// tracking_wheel_odometry: sequencer and pose state for arc odometry
// depends on trkodo_pkg, trkodo_mac, trkodo_cordic, trkodo_div
//
//   channel  | signals                                            | direction
//   ---------+----------------------------------------------------+----------
//   in       | in_valid/in_ready, command, *_turns, heading_now   | into block
//   out      | out_valid/out_ready, pos_x, pos_y, pose_heading    | out of block
//   cfg      | cfg_we, cfg_index, cfg_wdata                       | into block
//
// out_valid rises after a set-pose transfer by way of ST_FIN alone; an update spends
// most of its time in the divider and in two passes through the one cordic;
// with no heading change the chord terms, the first cordic pass and the divide are skipped;
// a saturated wheel travel skips its rounding step
// in_ready is high only while the sequencer is idle
// a result waits in the output register; the next item may start meanwhile,
// and its result stalls until the previous one is transferred
// reset loads pose and reference readings with zero and the registers with defaults
`timescale 1ns / 1ps
`default_nettype none

module tracking_wheel_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire        [2:0]  cfg_index,
	input  wire        [31:0] cfg_wdata,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               command,
	input  wire signed [31:0] sideways_turns,
	input  wire signed [31:0] forward_turns,
	input  wire        [15:0] heading_now,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic        [15:0] pose_heading
);

	localparam int CW = trkodo_pkg::CW;
	localparam int MW = trkodo_pkg::MW;
	localparam int AW = trkodo_pkg::AW;
	localparam int TW = trkodo_pkg::TW;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TR_MUL, ST_TR_RND, ST_TR_FIN, ST_HEAD, ST_COR1, ST_DEN, ST_DENW,
		ST_DIV, ST_LX_P0, ST_LX_P1, ST_LX_R, ST_LX_S, ST_ROT, ST_COR2, ST_GXW,
		ST_GYW, ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic        [19:0] diam_q;
	logic signed [24:0] soff_q, foff_q;
	logic        [31:0] start_x_q, start_y_q;
	logic        [15:0] start_h_q;

	// pose and references
	logic [31:0] pose_x_q, pose_y_q, last_side_q, last_fwd_q;
	logic [15:0] last_h_q;

	// item and working registers
	logic        [31:0] side_q, fwd_q;
	logic        [15:0] hnow_q;
	logic               w_q, tneg_q;
	logic signed [31:0] ts_q, tf_q, lx_q, ly_q;
	logic signed [15:0] d_q;
	logic signed [CW-1:0] s_q;
	logic        [trkodo_pkg::FW-1:0] f_q;
	logic signed [TW-1:0] tmp_q;

	logic        out_valid_q;
	logic [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;

	// shared units
	trkodo_pkg::mac_ctl_t  mac_ctl;
	logic signed [MW-1:0]  mac_a, mac_b;
	logic                  mac_busy;
	logic signed [AW-1:0]  acc;

	logic                  cor_start, cor_done;
	logic signed [CW-1:0]  cor_x0, cor_y0, cor_z0, cor_x, cor_y;

	logic                  div_start, div_done;
	logic [trkodo_pkg::DVW-1:0] div_dividend;
	logic [trkodo_pkg::DSW-1:0] div_divisor;
	logic [trkodo_pkg::FW-1:0]  div_quot;

	// combinational helpers
	logic        [31:0] cur, lst, dt, mag;
	logic signed [AW-1:0] m1, tr, r1, r2, gr;
	logic signed [31:0] tsel, tval;
	logic signed [24:0] osel;
	logic        [15:0] du;
	logic signed [CW-1:0] dsh, ph, lxe, lye;
	logic        [31:0] th, phi;
	logic        [31:0] smag;
	logic signed [TW:0]   lsum;
	logic signed [31:0] lsat;
	logic               m1_big;

	trkodo_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.busy   (mac_busy),
		.acc    (acc)
	);

	trkodo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.z0     (cor_z0),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y)
	);

	trkodo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	// wheel travel terms
	assign cur    = w_q ? fwd_q : side_q;
	assign lst    = w_q ? last_fwd_q : last_side_q;
	assign dt     = cur - lst;
	assign mag    = dt[31] ? (32'd0 - dt) : dt;
	assign m1     = trkodo_pkg::rnd_shift(acc, 16);
	assign m1_big = m1 >= AW'(64'sd2147483648);
	assign tr     = trkodo_pkg::rnd_shift(acc, 29);
	assign tval   = (tr > trkodo_pkg::SAT_POS) ? 32'sd2147483647 : tr[31:0];

	// heading terms
	assign du  = hnow_q - last_h_q;
	assign dsh = CW'(d_q) <<< 15;
	assign th  = {last_h_q, 16'd0} + dsh[31:0];
	assign phi = 32'd0 - th;
	assign lxe = CW'(lx_q);
	assign lye = CW'(ly_q);
	assign smag = s_q[CW-1] ? 32'(-s_q) : 32'(s_q);

	// local offset terms
	assign tsel = w_q ? tf_q : ts_q;
	assign osel = w_q ? foff_q : soff_q;
	assign r1   = trkodo_pkg::rnd_shift(acc, 30);
	assign r2   = trkodo_pkg::rnd_shift(acc, 29);
	assign lsum = (TW + 1)'(tmp_q) + r2[TW:0];
	assign lsat = (lsum > (TW + 1)'(trkodo_pkg::SAT_POS)) ? 32'sh7FFFFFFF :
	              (lsum < (TW + 1)'(trkodo_pkg::SAT_NEG)) ? 32'sh80000000 : lsum[31:0];
	assign gr   = trkodo_pkg::rnd_shift(acc, 30);
	assign ph   = CW'($signed(phi));

	// unit requests
	always_comb begin
		mac_ctl      = '0;
		mac_a        = '0;
		mac_b        = '0;
		cor_start    = 1'b0;
		cor_x0       = '0;
		cor_y0       = '0;
		cor_z0       = '0;
		div_start    = 1'b0;
		div_divisor  = acc[trkodo_pkg::DSW-1:0];
		div_dividend = {smag, 32'd0} + trkodo_pkg::DVW'(acc[trkodo_pkg::DSW-1:1]);
		unique case (state_q)
			ST_TR_MUL: begin
				mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
				mac_a   = MW'(mag);
				mac_b   = MW'(diam_q);
			end
			ST_TR_RND: begin
				if (!mac_busy && !m1_big) begin
					mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
					mac_a   = MW'(m1[30:0]);
					mac_b   = MW'(trkodo_pkg::PI_Q29);
				end
			end
			ST_HEAD: begin
				if (du != 16'd0) begin
					cor_start = 1'b1;
					cor_x0    = CW'(trkodo_pkg::GAIN_Q30);
					cor_z0    = CW'($signed(du)) <<< 15;
				end
			end
			ST_DEN: begin
				mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
				mac_a   = MW'(trkodo_pkg::PI_Q16);
				mac_b   = d_q[15] ? MW'(-d_q) : MW'(d_q);
			end
			ST_DENW: begin
				div_start = !mac_busy;
			end
			ST_LX_P0: begin
				mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
				mac_a   = MW'(tsel);
				mac_b   = MW'(f_q[31:0]);
			end
			ST_LX_P1: begin
				mac_ctl = '{issue: 1'b1, clear: 1'b0, hi: 1'b1};
				mac_a   = MW'(tsel);
				mac_b   = MW'(f_q[trkodo_pkg::FW-1:32]);
			end
			ST_LX_R: begin
				if (!mac_busy) begin
					mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
					mac_a   = MW'(osel);
					mac_b   = s_q[MW-1:0];
				end
			end
			ST_ROT: begin
				cor_start = 1'b1;
				if (ph > CW'(64'sd1073741824)) begin
					cor_x0 = -lxe;
					cor_y0 = -lye;
					cor_z0 = ph - CW'(64'sd2147483648);
				end else if (ph < -CW'(64'sd1073741824)) begin
					cor_x0 = -lxe;
					cor_y0 = -lye;
					cor_z0 = ph + CW'(64'sd2147483648);
				end else begin
					cor_x0 = lxe;
					cor_y0 = lye;
					cor_z0 = ph;
				end
			end
			ST_COR2: begin
				if (cor_done) begin
					mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
					mac_a   = cor_x[MW-1:0];
					mac_b   = MW'(trkodo_pkg::GAIN_Q30);
				end
			end
			ST_GXW: begin
				if (!mac_busy) begin
					mac_ctl = '{issue: 1'b1, clear: 1'b1, hi: 1'b0};
					mac_a   = cor_y[MW-1:0];
					mac_b   = MW'(trkodo_pkg::GAIN_Q30);
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q    <= 20'd180224;
			soff_q    <= '0;
			foff_q    <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trkodo_pkg::REG_WHEEL_DIAMETER:  diam_q    <= cfg_wdata[19:0];
				trkodo_pkg::REG_SIDEWAYS_OFFSET: soff_q    <= cfg_wdata[24:0];
				trkodo_pkg::REG_FORWARD_OFFSET:  foff_q    <= cfg_wdata[24:0];
				trkodo_pkg::REG_START_X:         start_x_q <= cfg_wdata;
				trkodo_pkg::REG_START_Y:         start_y_q <= cfg_wdata;
				trkodo_pkg::REG_START_HEADING:   start_h_q <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			last_side_q <= '0;
			last_fwd_q  <= '0;
			last_h_q    <= '0;
			out_valid_q <= 1'b0;
			w_q         <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						side_q <= sideways_turns;
						fwd_q  <= forward_turns;
						hnow_q <= heading_now;
						w_q    <= 1'b0;
						if (command == trkodo_pkg::CMD_SET_POSE) begin
							pose_x_q    <= start_x_q;
							pose_y_q    <= start_y_q;
							last_h_q    <= start_h_q;
							last_side_q <= sideways_turns;
							last_fwd_q  <= forward_turns;
							state_q     <= ST_FIN;
						end else begin
							state_q <= ST_TR_MUL;
						end
					end
				end
				ST_TR_MUL: begin
					tneg_q  <= dt[31];
					state_q <= ST_TR_RND;
				end
				ST_TR_RND: begin
					if (!mac_busy) begin
						if (m1_big) begin
							// travel too large, saturate
							if (w_q) tf_q <= tneg_q ? -32'sd2147483647 : 32'sd2147483647;
							else     ts_q <= tneg_q ? -32'sd2147483647 : 32'sd2147483647;
							w_q     <= 1'b1;
							state_q <= w_q ? ST_HEAD : ST_TR_MUL;
						end else begin
							state_q <= ST_TR_FIN;
						end
					end
				end
				ST_TR_FIN: begin
					if (!mac_busy) begin
						if (w_q) tf_q <= tneg_q ? -tval : tval;
						else     ts_q <= tneg_q ? -tval : tval;
						w_q     <= 1'b1;
						state_q <= w_q ? ST_HEAD : ST_TR_MUL;
					end
				end
				ST_HEAD: begin
					d_q <= $signed(du);
					w_q <= 1'b0;
					if (du == 16'd0) begin
						lx_q    <= ts_q;
						ly_q    <= tf_q;
						state_q <= ST_ROT;
					end else begin
						state_q <= ST_COR1;
					end
				end
				ST_COR1: begin
					if (cor_done) begin
						s_q     <= cor_y;
						state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					state_q <= ST_DENW;
				end
				ST_DENW: begin
					if (!mac_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						f_q     <= div_quot;
						state_q <= ST_LX_P0;
					end
				end
				ST_LX_P0: begin
					state_q <= ST_LX_P1;
				end
				ST_LX_P1: begin
					state_q <= ST_LX_R;
				end
				ST_LX_R: begin
					if (!mac_busy) begin
						tmp_q   <= r1[TW-1:0];
						state_q <= ST_LX_S;
					end
				end
				ST_LX_S: begin
					if (!mac_busy) begin
						if (w_q) ly_q <= lsat;
						else     lx_q <= lsat;
						w_q     <= 1'b1;
						state_q <= w_q ? ST_ROT : ST_LX_P0;
					end
				end
				ST_ROT: begin
					state_q <= ST_COR2;
				end
				ST_COR2: begin
					if (cor_done) begin
						state_q <= ST_GXW;
					end
				end
				ST_GXW: begin
					if (!mac_busy) begin
						pose_x_q <= pose_x_q + gr[31:0];
						state_q  <= ST_GYW;
					end
				end
				ST_GYW: begin
					if (!mac_busy) begin
						pose_y_q    <= pose_y_q + gr[31:0];
						last_side_q <= side_q;
						last_fwd_q  <= fwd_q;
						last_h_q    <= hnow_q;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_x_q     <= pose_x_q;
						out_y_q     <= pose_y_q;
						out_h_q     <= last_h_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = state_q == ST_IDLE;
	assign out_valid    = out_valid_q;
	assign pos_x        = out_x_q;
	assign pos_y        = out_y_q;
	assign pose_heading = out_h_q;

endmodule

`default_nettype wire

[design/trkodo_chk.sv]
// trkodo_chk: port-level checks for tracking_wheel_odometry, bound to the top
// depends only on the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module trkodo_chk (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] pos_y,
	input wire       [15:0] pose_heading
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(pose_heading))
		else $error("result changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transfer");

	// idle block has no second result queued
	a_idle_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid && out_ready |=> !out_valid)
		else $error("result appeared with no item in work");

	// results are produced by finished work only
	a_rise_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");

endmodule

bind tracking_wheel_odometry trkodo_chk u_trkodo_chk (.*);

`default_nettype wire

[sim/tracking_wheel_odometry_test.sv]
// tracking_wheel_odometry_test: self-checking bench for the arc odometry block
// depends on trkodo_pkg and tracking_wheel_odometry; a pose tracker predicts each result
`timescale 1ns / 1ps
`default_nettype none

class pose_tracker;
	bit [19:0] wheel_dia;
	bit [24:0] side_off, fwd_off;
	bit [31:0] start_px, start_py;
	bit [15:0] start_hd;
	bit [31:0] px, py, last_side, last_fwd;
	bit [15:0] last_hd;
	bit [31:0] exp_x[$], exp_y[$];
	bit [15:0] exp_h[$];
	int errors;
	int checked;

	function void reset_state();
		wheel_dia = 20'd180224;
		side_off = '0; fwd_off = '0;
		start_px = '0; start_py = '0; start_hd = '0;
		px = '0; py = '0; last_side = '0; last_fwd = '0; last_hd = '0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			trkodo_pkg::REG_WHEEL_DIAMETER:  wheel_dia = v[19:0];
			trkodo_pkg::REG_SIDEWAYS_OFFSET: side_off = v[24:0];
			trkodo_pkg::REG_FORWARD_OFFSET:  fwd_off = v[24:0];
			trkodo_pkg::REG_START_X:         start_px = v;
			trkodo_pkg::REG_START_Y:         start_py = v;
			trkodo_pkg::REG_START_HEADING:   start_hd = v[15:0];
			default: ;
		endcase
	endfunction

	static function longint shr_round(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	static function longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	static function void rotate(inout longint x, inout longint y, input longint z);
		longint dx, dy;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(trkodo_pkg::atan_turn(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(trkodo_pkg::atan_turn(5'(i)));
			end
		end
	endfunction

	function longint wheel_travel(bit [31:0] now_t, bit [31:0] prev_t);
		bit [31:0] diff;
		longint dt;
		longint unsigned mag, m1, t;
		diff = now_t - prev_t;
		dt = longint'(signed'(diff));
		mag = dt < 0 ? -dt : dt;
		m1 = (mag * wheel_dia + 32768) >> 16;
		if (m1 >= 64'h8000_0000) t = 2147483647;
		else begin
			t = (m1 * 64'd1686629713 + (64'd1 << 28)) >> 29;
			if (t > 2147483647) t = 2147483647;
		end
		return dt < 0 ? -longint'(t) : longint'(t);
	endfunction

	function void note_input(bit cmd, bit [31:0] side, bit [31:0] fwd, bit [15:0] hnow);
		longint ts, tf, d, lx, ly, x, y, ph, sx, s, sf, fo;
		longint unsigned smag, dmag, den, f;
		bit [15:0] du;
		bit [31:0] th;
		if (cmd == trkodo_pkg::CMD_SET_POSE) begin
			px = start_px; py = start_py; last_hd = start_hd;
			last_side = side; last_fwd = fwd;
		end else begin
			ts = wheel_travel(side, last_side);
			tf = wheel_travel(fwd, last_fwd);
			du = hnow - last_hd;
			d = longint'(signed'(du));
			if (d == 0) begin
				lx = ts; ly = tf;
			end else begin
				sx = 652032874; s = 0;
				rotate(sx, s, d * 32768);
				smag = s < 0 ? -s : s;
				dmag = d < 0 ? -d : d;
				den = 64'd205887 * dmag;
				f = ((smag << 32) + den / 2) / den;
				sf = longint'(signed'(side_off));
				fo = longint'(signed'(fwd_off));
				lx = sat32(shr_round(ts * longint'(f), 30) + shr_round(sf * s, 29));
				ly = sat32(shr_round(tf * longint'(f), 30) + shr_round(fo * s, 29));
			end
			th = {last_hd, 16'h0} + 32'(d * 32768);
			ph = longint'(signed'(32'h0 - th));
			x = lx; y = ly;
			if (ph > (64'sd1 <<< 30)) begin
				ph -= 64'sd1 <<< 31; x = -x; y = -y;
			end else if (ph < -(64'sd1 <<< 30)) begin
				ph += 64'sd1 <<< 31; x = -x; y = -y;
			end
			rotate(x, y, ph);
			x = shr_round(x * 652032874, 30);
			y = shr_round(y * 652032874, 30);
			px = px + 32'(x);
			py = py + 32'(y);
			last_side = side; last_fwd = fwd; last_hd = hnow;
		end
		exp_x.push_back(px); exp_y.push_back(py); exp_h.push_back(last_hd);
	endfunction

	function void check_result(bit [31:0] ax, bit [31:0] ay, bit [15:0] ah);
		bit [31:0] ex, ey;
		bit [15:0] eh;
		if (exp_x.size() == 0) begin
			$error("unexpected result x=%h y=%h heading=%h", ax, ay, ah);
			errors++;
			return;
		end
		ex = exp_x.pop_front(); ey = exp_y.pop_front(); eh = exp_h.pop_front();
		checked++;
		if (ax !== ex) begin
			$error("pos_x expected %h actual %h", ex, ax); errors++;
		end
		if (ay !== ey) begin
			$error("pos_y expected %h actual %h", ey, ay); errors++;
		end
		if (ah !== eh) begin
			$error("pose_heading expected %h actual %h", eh, ah); errors++;
		end
	endfunction

	function int pending();
		return exp_x.size();
	endfunction
endclass

module tracking_wheel_odometry_test;

	localparam longint CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic signed [31:0] sideways_turns = '0;
	logic signed [31:0] forward_turns = '0;
	logic [15:0] heading_now = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y;
	logic [15:0] pose_heading;

	pose_tracker track = new();
	longint cycles = 0;
	bit hold_out = 1'b0;
	int n_update = 0, n_setpose = 0;

	// reference readings the random sequences move around
	bit [31:0] cur_side = '0, cur_fwd = '0;
	bit [15:0] cur_hd = '0;

	tracking_wheel_odometry dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tracking_wheel_odometry verification failed");
			$finish;
		end
	end

	// receiver side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (out_valid && out_ready)
			track.check_result(pos_x, pos_y, pose_heading);
		if (hold_out) out_ready <= 1'b0;
		else if ($urandom_range(0, 9) < 7) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 19) == 0);
	end

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 9);
		if (g < 5) g = 0;
		else if (g < 9) g = $urandom_range(1, 4);
		else g = $urandom_range(20, 200);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// valid stays high after the transfer so the next item can follow at once
	task automatic send_item(bit cmd, bit [31:0] side, bit [31:0] fwd, bit [15:0] hnow);
		command <= cmd;
		sideways_turns <= side;
		forward_turns <= fwd;
		heading_now <= hnow;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		track.note_input(cmd, side, fwd, hnow);
		if (cmd == trkodo_pkg::CMD_SET_POSE) n_setpose++; else n_update++;
	endtask

	task automatic send_gapped(bit cmd, bit [31:0] side, bit [31:0] fwd, bit [15:0] hnow);
		send_item(cmd, side, fwd, hnow);
		idle_gap();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (track.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		track.write_reg(idx, v);
	endtask

	task automatic load_regs(bit [19:0] dia, bit [24:0] so, bit [24:0] fo,
			bit [31:0] sx, bit [31:0] sy, bit [15:0] sh);
		write_reg(trkodo_pkg::REG_WHEEL_DIAMETER, {12'h0, dia});
		write_reg(trkodo_pkg::REG_SIDEWAYS_OFFSET, {{7{so[24]}}, so});
		write_reg(trkodo_pkg::REG_FORWARD_OFFSET, {{7{fo[24]}}, fo});
		write_reg(trkodo_pkg::REG_START_X, sx);
		write_reg(trkodo_pkg::REG_START_Y, sy);
		write_reg(trkodo_pkg::REG_START_HEADING, {16'h0, sh});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly realistic motion: small wheel steps and small heading changes
	task automatic random_phase(int count);
		bit [31:0] s, f;
		bit [15:0] h;
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 19);
			if (k == 0) begin
				cur_side = $urandom(); cur_fwd = $urandom(); cur_hd = 16'($urandom());
				send_gapped(trkodo_pkg::CMD_SET_POSE, cur_side, cur_fwd, cur_hd);
				cur_hd = track.last_hd;
			end else if (k < 3) begin
				// raw noise, any value in every field
				s = $urandom(); f = $urandom(); h = 16'($urandom());
				send_gapped(trkodo_pkg::CMD_UPDATE, s, f, h);
				cur_side = s; cur_fwd = f; cur_hd = h;
			end else begin
				cur_side = cur_side + 32'($signed($urandom_range(0, 262144)) - 131072);
				cur_fwd = cur_fwd + 32'($signed($urandom_range(0, 262144)) - 131072);
				if ($urandom_range(0, 3) == 0) h = cur_hd;
				else h = cur_hd + 16'($signed($urandom_range(0, 4000)) - 2000);
				cur_hd = h;
				send_gapped(trkodo_pkg::CMD_UPDATE, cur_side, cur_fwd, cur_hd);
			end
		end
	endtask

	initial begin
		track.reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default registers, extremes, half turn, no heading change
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0001_0000, 32'h0002_0000, 16'h0000);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0002_0000, 32'h0001_0000, 16'h0100);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8100);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_item(trkodo_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h7FFF);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h7FFF);
		send_item(trkodo_pkg::CMD_SET_POSE, 32'h1234_5678, 32'h9ABC_DEF0, 16'h4321);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h1235_5678, 32'h9ABB_DEF0, 16'h4000);
		drain();
		load_regs(20'hFFFFF, 25'h0FF_FFFF, 25'h100_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			16'hFFFF);
		send_item(trkodo_pkg::CMD_SET_POSE, 32'h0, 32'h0, 16'h0);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0001);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0002);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h4000_0000, 32'hC000_0000, 16'h8002);
		drain();
		load_regs(20'h0, 25'h100_0000, 25'h0FF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'h8000);
		send_item(trkodo_pkg::CMD_SET_POSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h0, 32'h0, 16'h0000);
		send_item(trkodo_pkg::CMD_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
		drain();
		cur_side = track.last_side; cur_fwd = track.last_fwd; cur_hd = track.last_hd;

		// several register settings, random content in each
		for (int p = 0; p < 6; p++) begin
			load_regs(20'($urandom()), 25'($urandom()), 25'($urandom()), $urandom(),
				$urandom(), 16'($urandom()));
			if (p == 0) load_regs(20'd180224, 25'h0, 25'h0, 32'h0, 32'h0, 16'h0);
			random_phase(200);
			if (p == 2) begin
				// long receiver hold-off while items keep coming
				hold_out = 1'b1;
				fork
					begin
						repeat (3000) @(posedge clk);
						hold_out = 1'b0;
					end
					begin
						for (int i = 0; i < 6; i++) begin
							cur_side = cur_side + 32'h100;
							send_item(trkodo_pkg::CMD_UPDATE, cur_side, cur_fwd,
								cur_hd + 16'(i));
						end
						in_valid <= 1'b0;
					end
				join
				cur_hd = track.last_hd;
			end
			drain();
		end

		drain();
		$display("covered %0d updates and %0d set-pose items, %0d results compared",
			n_update, n_setpose, track.checked);
		if (track.errors == 0 && track.pending() == 0)
			$display("tracking_wheel_odometry verification clean");
		else
			$display("tracking_wheel_odometry verification failed");
		$finish;
	end
endmodule

`default_nettype wire

[files.f]
design/trkodo_pkg.sv
design/trkodo_mac.sv
design/trkodo_cordic.sv
design/trkodo_div.sv
design/tracking_wheel_odometry.sv
design/trkodo_chk.sv
sim/tracking_wheel_odometry_test.sv
